// ===== sv/athr_pkg.sv =====
// Shared constants and types for the adaptive-threshold heart-rate block.
package athr_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_REFRACTORY = 3'd0,
        CFG_TICK_MS    = 3'd1,
        CFG_BPM_MIN    = 3'd2,
        CFG_BPM_MAX    = 3'd3
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned REFR_W     = 16;
    localparam int unsigned PERIOD_W   = 10;
    localparam int unsigned BPM_W      = 8;
    localparam int unsigned CROSS_W    = 8;
    localparam int unsigned SPAN_W     = TICK_W + PERIOD_W;
    localparam int unsigned QUOT_W     = 16;
    localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W);

    // Reset values of the registers
    localparam logic [REFR_W-1:0]   REFR_RST   = 16'd300;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd1;
    localparam logic [BPM_W-1:0]    BPM_MIN_RST = 8'd30;
    localparam logic [BPM_W-1:0]    BPM_MAX_RST = 8'd220;

    // Rate numerator (ms per minute) and crossing-count limits
    localparam logic [QUOT_W-1:0]  RATE_NUM  = 16'd60000;
    localparam logic [CROSS_W-1:0] CROSS_SAT = 8'd255;
    localparam logic [CROSS_W-1:0] CROSS_MIN = 8'd2;

endpackage

// ===== sv/adaptive_threshold_heart_rate.sv =====
// Heart-rate detector: adaptive-threshold crossing on a PPG stream, serial min/max and divide.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready   | s_sample[23:0], s_now_ticks[31:0]
//  m_      | out       | m_valid / m_ready   | m_rate_bpm[7:0], m_rate_valid, m_beat_seen
//  cfg_    | in        | cfg_we (no wait)    | cfg_index[2:0], cfg_wdata[15:0]
//
//  Each transaction runs from acceptance to result through a serial min/max scan over the ring
//    memory through its single read port, once the ring is full, and then a 16-step restoring
//    divide; while the ring is still filling, the scan is skipped.
//  s_ready is high only in IDLE; the result register lets the next sample be taken while a
//    finished result is still waiting on m_ready.
//  A stalled m_ready holds the sequencer in FINISH until the result register is free.
//  Reset (aresetn, synchronous, active low) clears control state and loads register defaults;
//    ring contents are not cleared and are never read before being written.
module adaptive_threshold_heart_rate #(
    parameter int unsigned HISTORY_DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [athr_pkg::SAMPLE_W-1:0]       s_sample,
    input  logic [athr_pkg::TICK_W-1:0]         s_now_ticks,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [athr_pkg::BPM_W-1:0]          m_rate_bpm,
    output logic                                m_rate_valid,
    output logic                                m_beat_seen,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [athr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [athr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);      // ring address width
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);  // fill / scan count width
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MULT,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [athr_pkg::REFR_W-1:0]   refr_reg;
    logic [athr_pkg::PERIOD_W-1:0] period_reg;
    logic [athr_pkg::BPM_W-1:0]    bpm_min_reg;
    logic [athr_pkg::BPM_W-1:0]    bpm_max_reg;

    // detector state
    logic [AW-1:0]                 write_pos_reg;
    logic [CW-1:0]                 fill_count_reg;
    logic [athr_pkg::SAMPLE_W-1:0] prev_sample_reg;
    logic [athr_pkg::TICK_W-1:0]   last_cross_reg;
    logic [athr_pkg::TICK_W-1:0]   interval_reg;
    logic [athr_pkg::CROSS_W-1:0]  crossings_reg;

    // working registers for the transaction in flight
    logic [athr_pkg::SAMPLE_W-1:0] sample_reg;
    logic [athr_pkg::TICK_W-1:0]   now_reg;
    logic [CW-1:0]                 scan_cnt_reg;
    logic [athr_pkg::SAMPLE_W-1:0] lo_reg;
    logic [athr_pkg::SAMPLE_W-1:0] hi_reg;
    logic                          beat_reg;
    logic [athr_pkg::SPAN_W-1:0]   span_reg;
    logic                          rate_ok_reg;
    logic [athr_pkg::QUOT_W-1:0]   divisor_reg;
    logic [athr_pkg::QUOT_W-1:0]   rem_reg;
    logic [athr_pkg::QUOT_W-1:0]   quot_reg;   // dividend shifts out, quotient shifts in
    logic [athr_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // result register
    logic                          m_valid_reg;
    logic [athr_pkg::BPM_W-1:0]    m_rate_bpm_reg;
    logic                          m_rate_valid_reg;
    logic                          m_beat_seen_reg;

    // ring memory, one write and one registered read port
    logic [athr_pkg::SAMPLE_W-1:0] win_mem [HISTORY_DEPTH];
    logic [athr_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]                 rd_addr;

    logic                          s_accept;
    logic [CW-1:0]                 fill_inc;
    logic [athr_pkg::SAMPLE_W-1:0] thr;
    logic                          crossing;
    logic [athr_pkg::TICK_W-1:0]   elapsed;
    logic [athr_pkg::QUOT_W:0]     trial;
    logic                          trial_ge;
    logic                          in_range;
    logic                          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign fill_inc = (fill_count_reg == DEPTH_C) ? fill_count_reg : fill_count_reg + CW'(1);

    // Scan issues addresses 0..DEPTH-1; the extra cycle only drains the read register
    assign rd_addr = (scan_cnt_reg < DEPTH_C) ? scan_cnt_reg[AW-1:0] : '0;

    // midpoint threshold, truncated
    assign thr      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign crossing = (prev_sample_reg < thr) && (sample_reg >= thr);
    assign elapsed  = now_reg - last_cross_reg;   // wraps modulo 2^32

    // one restoring-divide step
    assign trial    = {rem_reg, quot_reg[athr_pkg::QUOT_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    assign in_range = rate_ok_reg
                   && (quot_reg >= athr_pkg::QUOT_W'(bpm_min_reg))
                   && (quot_reg <= athr_pkg::QUOT_W'(bpm_max_reg));

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            win_mem[write_pos_reg] <= s_sample;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            refr_reg         <= athr_pkg::REFR_RST;
            period_reg       <= athr_pkg::PERIOD_RST;
            bpm_min_reg      <= athr_pkg::BPM_MIN_RST;
            bpm_max_reg      <= athr_pkg::BPM_MAX_RST;
            write_pos_reg    <= '0;
            fill_count_reg   <= '0;
            prev_sample_reg  <= '0;
            last_cross_reg   <= '0;
            interval_reg     <= '0;
            crossings_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    athr_pkg::CFG_REFRACTORY: refr_reg    <= cfg_wdata[athr_pkg::REFR_W-1:0];
                    athr_pkg::CFG_TICK_MS:    period_reg  <= cfg_wdata[athr_pkg::PERIOD_W-1:0];
                    athr_pkg::CFG_BPM_MIN:    bpm_min_reg <= cfg_wdata[athr_pkg::BPM_W-1:0];
                    athr_pkg::CFG_BPM_MAX:    bpm_max_reg <= cfg_wdata[athr_pkg::BPM_W-1:0];
                    default: ;
                endcase
            end

            // result taken; in FINISH the load below decides the flag on its own
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        sample_reg     <= s_sample;
                        now_reg        <= s_now_ticks;
                        beat_reg       <= 1'b0;
                        scan_cnt_reg   <= '0;
                        fill_count_reg <= fill_inc;
                        write_pos_reg  <= (write_pos_reg == LAST_POS) ? '0
                                                                       : write_pos_reg + AW'(1);
                        state_reg      <= (fill_inc == DEPTH_C) ? ST_SCAN : ST_MULT;
                    end
                end
                ST_SCAN: begin
                    if (scan_cnt_reg == CW'(1)) begin
                        lo_reg <= rd_data_reg;
                        hi_reg <= rd_data_reg;
                    end else if (scan_cnt_reg != '0) begin
                        if (rd_data_reg < lo_reg) lo_reg <= rd_data_reg;
                        if (rd_data_reg > hi_reg) hi_reg <= rd_data_reg;
                    end
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                    if (scan_cnt_reg == DEPTH_C) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (crossing) begin
                        if (crossings_reg == '0) begin
                            last_cross_reg <= now_reg;
                            crossings_reg  <= athr_pkg::CROSS_W'(1);
                            beat_reg       <= 1'b1;
                        end else if (elapsed >= athr_pkg::TICK_W'(refr_reg)) begin
                            interval_reg   <= elapsed;
                            last_cross_reg <= now_reg;
                            if (crossings_reg != athr_pkg::CROSS_SAT) begin
                                crossings_reg <= crossings_reg + athr_pkg::CROSS_W'(1);
                            end
                            beat_reg       <= 1'b1;
                        end
                    end
                    state_reg <= ST_MULT;
                end
                ST_MULT: begin
                    prev_sample_reg <= sample_reg;
                    span_reg  <= athr_pkg::SPAN_W'(interval_reg)
                               * athr_pkg::SPAN_W'(period_reg);
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    rate_ok_reg <= (crossings_reg >= athr_pkg::CROSS_MIN) && (span_reg != '0);
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    divisor_reg <= span_reg[athr_pkg::QUOT_W-1:0];
                    // span beyond the numerator gives a zero quotient, and a zero span cannot divide: skip the divide
                    if (span_reg > athr_pkg::SPAN_W'(athr_pkg::RATE_NUM) || span_reg == '0) begin
                        quot_reg  <= '0;
                        state_reg <= ST_FINISH;
                    end else begin
                        quot_reg  <= athr_pkg::RATE_NUM;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (trial_ge) begin
                        rem_reg <= athr_pkg::QUOT_W'(trial - {1'b0, divisor_reg});
                    end else begin
                        rem_reg <= trial[athr_pkg::QUOT_W-1:0];
                    end
                    quot_reg    <= {quot_reg[athr_pkg::QUOT_W-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg + athr_pkg::DIV_CNT_W'(1);
                    if (div_cnt_reg == athr_pkg::DIV_CNT_W'(athr_pkg::QUOT_W - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_rate_valid_reg <= in_range;
                        m_rate_bpm_reg   <= in_range ? quot_reg[athr_pkg::BPM_W-1:0] : '0;
                        m_beat_seen_reg  <= beat_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rate_bpm   = m_rate_bpm_reg;
    assign m_rate_valid = m_rate_valid_reg;
    assign m_beat_seen  = m_beat_seen_reg;

    // an invalid rate is always reported as zero
    a_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_rate_valid_reg) |-> (m_rate_bpm_reg == '0))
        else $error("rate not zero on invalid result");

    // a reported beat means at least one crossing is on record
    a_beat_has_crossing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_beat_seen_reg) |-> (crossings_reg != '0))
        else $error("beat reported with no crossing count");

    // crossing count never falls back to zero outside reset
    a_crossings_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (crossings_reg != '0) |=> (crossings_reg != '0))
        else $error("crossing count lost");

    // fill count saturates at the ring depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= DEPTH_C)
        else $error("fill count beyond ring depth");

    // the result register is only overwritten once free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("pending result dropped");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the PPG heart-rate detector: synthetic pulse trains against a scoreboard.
module tb_top;

    localparam int unsigned CLK_PERIOD      = 10;
    localparam int unsigned RING_DEPTH      = 32;
    localparam int unsigned PHASES          = 9;
    localparam int unsigned HOLD_OFF_CYCLES = 400;   // long result-side stall, fills the block
    localparam int unsigned STALL_LIMIT     = 4000;  // cycles without any transaction
    localparam int unsigned DRAIN_CYCLES    = 80;    // comfortably above the longest transaction
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned SAMPLE_MAX      = 24'hFFFFFF;
    // An index past the register list; the block must ignore writes to it
    localparam logic [athr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;
    // Timestamp just below the 32-bit wrap, so the early intervals straddle it
    localparam logic [athr_pkg::TICK_W-1:0]    WRAP_EDGE      = 32'hFFFF_FF80;

    // One result transaction, as seen on the m_ channel
    typedef struct packed {
        logic [athr_pkg::BPM_W-1:0] bpm;
        logic                       valid;
        logic                       beat;
    } rate_result_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    logic [athr_pkg::SAMPLE_W-1:0]   s_sample    = '0;
    logic [athr_pkg::TICK_W-1:0]     s_now_ticks = '0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    logic [athr_pkg::BPM_W-1:0]      m_rate_bpm;
    logic                            m_rate_valid;
    logic                            m_beat_seen;
    logic                            cfg_we      = 1'b0;
    logic [athr_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [athr_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;

    // Run control shared between the stimulus, the receiver and the watchdog
    bit                   sender_gaps     = 1'b1;
    bit                   receiver_gaps   = 1'b1;
    bit                   hold_off_request = 1'b0;
    bit                   run_done        = 1'b0;
    int unsigned          stall_cycles    = 0;
    int unsigned          settings_applied = 0;
    logic [athr_pkg::TICK_W-1:0] stamp;

    // Scoreboard: tracks the detector state and queues the expected result per sample
    class heart_rate_scoreboard;
        logic [athr_pkg::REFR_W-1:0]   refractory;
        logic [athr_pkg::PERIOD_W-1:0] tick_ms;
        logic [athr_pkg::BPM_W-1:0]    bpm_lo;
        logic [athr_pkg::BPM_W-1:0]    bpm_hi;

        logic [athr_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
        int unsigned                   ring_pos;
        int unsigned                   ring_fill;
        logic [athr_pkg::SAMPLE_W-1:0] last_sample;
        logic [athr_pkg::TICK_W-1:0]   last_beat_time;
        logic [athr_pkg::TICK_W-1:0]   beat_interval;
        logic [athr_pkg::CROSS_W-1:0]  beat_count;

        rate_result_t        expected_rates [$];
        int unsigned         samples_seen;
        int unsigned         beats_predicted;
        int unsigned         results_checked;
        int unsigned         valid_rates;
        int unsigned         mismatches;
        bit                  saturated;

        function new();
            refractory      = athr_pkg::REFR_RST;
            tick_ms         = athr_pkg::PERIOD_RST;
            bpm_lo          = athr_pkg::BPM_MIN_RST;
            bpm_hi          = athr_pkg::BPM_MAX_RST;
            ring_pos        = 0;
            ring_fill       = 0;
            last_sample     = '0;
            last_beat_time  = '0;
            beat_interval   = '0;
            beat_count      = '0;
            samples_seen    = 0;
            beats_predicted = 0;
            results_checked = 0;
            valid_rates     = 0;
            mismatches      = 0;
            saturated       = 1'b0;
        endfunction

        // Register write; upper data bits beyond each register are dropped
        function void write_reg(logic [athr_pkg::CFG_IDX_W-1:0] idx,
                                logic [athr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                athr_pkg::CFG_REFRACTORY: refractory = data[athr_pkg::REFR_W-1:0];
                athr_pkg::CFG_TICK_MS:    tick_ms    = data[athr_pkg::PERIOD_W-1:0];
                athr_pkg::CFG_BPM_MIN:    bpm_lo     = data[athr_pkg::BPM_W-1:0];
                athr_pkg::CFG_BPM_MAX:    bpm_hi     = data[athr_pkg::BPM_W-1:0];
                default: ;
            endcase
        endfunction

        // Accepted sample: update ring, crossing state and the expected rate
        function void track_sample(logic [athr_pkg::SAMPLE_W-1:0] smp,
                                   logic [athr_pkg::TICK_W-1:0] now);
            rate_result_t                  res;
            logic [athr_pkg::SAMPLE_W-1:0] lo;
            logic [athr_pkg::SAMPLE_W-1:0] hi;
            logic [athr_pkg::SAMPLE_W-1:0] thr;
            logic [athr_pkg::TICK_W-1:0]   elapsed;
            logic [63:0]                   span;
            logic [63:0]                   quot;
            res = '0;
            ring[ring_pos] = smp;
            ring_pos = (ring_pos + 1) % RING_DEPTH;
            if (ring_fill < RING_DEPTH) ring_fill++;

            // threshold test only once the ring holds a full history
            if (ring_fill == RING_DEPTH) begin
                lo = ring[0];
                hi = ring[0];
                foreach (ring[k]) begin
                    if (ring[k] < lo) lo = ring[k];
                    if (ring[k] > hi) hi = ring[k];
                end
                thr = lo + ((hi - lo) >> 1);
                if (last_sample < thr && smp >= thr) begin
                    elapsed = now - last_beat_time;   // wraps modulo 2^32
                    if (beat_count == '0) begin
                        last_beat_time = now;
                        beat_count     = athr_pkg::CROSS_W'(1);
                        res.beat       = 1'b1;
                    end else if (elapsed >= refractory) begin
                        beat_interval  = elapsed;
                        last_beat_time = now;
                        if (beat_count != athr_pkg::CROSS_SAT) beat_count++;
                        res.beat       = 1'b1;
                    end
                end
            end
            last_sample = smp;

            // wide product, so large intervals never wrap into a bogus rate
            if (beat_count >= athr_pkg::CROSS_MIN) begin
                span = 64'(beat_interval) * 64'(tick_ms);
                if (span != 0) begin
                    quot = 64'(athr_pkg::RATE_NUM) / span;
                    if (quot >= bpm_lo && quot <= bpm_hi) begin
                        res.bpm   = quot[athr_pkg::BPM_W-1:0];
                        res.valid = 1'b1;
                    end
                end
            end

            if (beat_count == athr_pkg::CROSS_SAT) saturated = 1'b1;
            if (res.beat) beats_predicted++;
            samples_seen++;
            expected_rates.push_back(res);
        endfunction

        function void check_result(logic [athr_pkg::BPM_W-1:0] bpm, logic valid, logic beat);
            rate_result_t want;
            if (expected_rates.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result: rate_bpm %0d valid %0b beat %0b",
                             $time, bpm, valid, beat);
                return;
            end
            want = expected_rates.pop_front();
            results_checked++;
            if (bpm !== want.bpm || valid !== want.valid || beat !== want.beat) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display(
                        "%0t: result %0d: bpm exp %0d got %0d, valid exp %0b got %0b, %s",
                        $time, results_checked, want.bpm, bpm, want.valid, valid,
                        $sformatf("beat exp %0b got %0b", want.beat, beat));
            end else if (valid) begin
                valid_rates++;
            end
        endfunction
    endclass

    heart_rate_scoreboard sb = new();

    adaptive_threshold_heart_rate #(
        .HISTORY_DEPTH (RING_DEPTH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_now_ticks  (s_now_ticks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rate_bpm   (m_rate_bpm),
        .m_rate_valid (m_rate_valid),
        .m_beat_seen  (m_beat_seen),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // One sample transaction. Called at a rising edge; returns at the edge of acceptance
    // with s_valid still high, so a back-to-back sample never drops valid.
    task automatic send_sample(input logic [athr_pkg::SAMPLE_W-1:0] smp,
                               input logic [athr_pkg::TICK_W-1:0] now);
        int unsigned gap;
        gap = sender_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample    <= smp;
        s_now_ticks <= now;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.track_sample(smp, now);
    endtask

    task automatic write_reg(input logic [athr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [athr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Full register set; junk above each narrower register's width, plus a stray write past the list
    task automatic apply_settings(input logic [athr_pkg::REFR_W-1:0] refr,
                                  input logic [athr_pkg::PERIOD_W-1:0] tick,
                                  input logic [athr_pkg::BPM_W-1:0] lo,
                                  input logic [athr_pkg::BPM_W-1:0] hi);
        write_reg(athr_pkg::CFG_REFRACTORY, refr);
        write_reg(athr_pkg::CFG_TICK_MS, {6'($urandom), tick});
        write_reg(athr_pkg::CFG_BPM_MIN, {8'($urandom), lo});
        write_reg(athr_pkg::CFG_BPM_MAX, {8'($urandom), hi});
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Square-ish pulse train: low half then high half of each period, small noise on top,
    // with the odd wild sample and the odd timestamp jump mixed in.
    task automatic send_heartbeat_train(input int unsigned n_items, input int unsigned step_lo,
                                        input int unsigned step_hi, input int unsigned period_hi,
                                        input bit until_saturated);
        int unsigned                   period;
        int unsigned                   pos;
        int unsigned                   base;
        int unsigned                   amp;
        int unsigned                   level;
        int unsigned                   i;
        logic [athr_pkg::SAMPLE_W-1:0] smp;
        pos    = 0;
        i      = 0;
        period = 2;
        base   = 0;
        amp    = 0;
        while (i < n_items || (until_saturated && !sb.saturated)) begin
            if (pos == 0 && (i == 0 || $urandom_range(0, 7) == 0)) begin
                period = $urandom_range(2, period_hi);
                amp    = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 255)
                                                     : $urandom_range(1024, SAMPLE_MAX);
                base   = $urandom_range(0, SAMPLE_MAX - amp);
            end
            level = (pos < period / 2) ? base : base + amp;
            level += $urandom_range(0, amp / 8);
            if (level > SAMPLE_MAX) level = SAMPLE_MAX;
            smp   = level[athr_pkg::SAMPLE_W-1:0];
            stamp += $urandom_range(step_lo, step_hi);
            if ($urandom_range(0, 11) == 0) smp = athr_pkg::SAMPLE_W'($urandom);
            if ($urandom_range(0, 29) == 0) stamp = $urandom;
            send_sample(smp, stamp);
            pos = (pos + 1) % period;
            i++;
        end
    endtask

    // Result side: random ready stalls, plus one long hold-off on request
    initial begin
        int unsigned gap;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off_request) begin
                gap = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end else begin
                gap = receiver_gaps ? $urandom_range(0, 15) : 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_result(m_rate_bpm, m_rate_valid, m_beat_seen);
        end
    end

    // Watchdog: too long without any transaction on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || run_done || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, sb.expected_rates.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [athr_pkg::SAMPLE_W-1:0] smp;
        logic [athr_pkg::TICK_W-1:0]   now;
        int unsigned                   phase;
        int unsigned                   step_lo;
        int unsigned                   step_hi;
        int unsigned                   period_hi;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset register values.
        // Fill the ring with the two rails (and a pair either side of mid-scale), so the
        // threshold settles at 0x7FFFFF; the last fill sample gives the first crossing.
        for (int k = 0; k < RING_DEPTH; k++) begin
            if (k == 2)      smp = 24'h800000;
            else if (k == 4) smp = 24'h7FFFFF;
            else             smp = k[0] ? '1 : '0;
            if (k == 0)                   now = '0;
            else if (k == 1)              now = '1;
            else if (k == RING_DEPTH - 1) now = WRAP_EDGE;
            else                          now = $urandom;
            send_sample(smp, now);
        end
        send_sample(24'h000000, WRAP_EDGE + 32'd10);
        send_sample(24'hFFFFFF, WRAP_EDGE + 32'd299);   // inside refractory, dropped
        send_sample(24'h000000, WRAP_EDGE + 32'd320);
        send_sample(24'h7FFFFF, WRAP_EDGE + 32'd400);   // equal to threshold, time wraps
        send_sample(24'h7FFFFE, WRAP_EDGE + 32'd500);
        send_sample(24'hFFFFFF, WRAP_EDGE + 32'd700);   // elapsed exactly the refractory
        send_sample(24'h000000, WRAP_EDGE + 32'd800);
        send_sample(24'hFFFFFF, WRAP_EDGE + 32'd2701);  // 29 bpm, below the floor
        send_sample(24'h000000, WRAP_EDGE + 32'd2800);
        send_sample(24'hFFFFFF, WRAP_EDGE + 32'd4701);  // 30 bpm, on the floor
        s_valid <= 1'b0;
        stamp = WRAP_EDGE + 32'd4701;

        // Random part: one register setting per phase, settings only touched once idle
        for (phase = 0; phase < PHASES; phase++) begin
            while (sb.expected_rates.size() != 0) @(posedge aclk);
            repeat (4) @(posedge aclk);
            step_lo   = 1;
            step_hi   = 250;
            period_hi = 24;
            case (phase)
                0: begin
                    apply_settings(athr_pkg::REFR_RST, athr_pkg::PERIOD_RST,
                                   athr_pkg::BPM_MIN_RST, athr_pkg::BPM_MAX_RST);
                    step_lo = 20;
                    step_hi = 120;
                end
                1: begin
                    // zero refractory, 1000 ms tick: long intervals truncate to a valid zero rate
                    apply_settings(16'd0, 10'd1000, 8'd0, 8'd255);
                    step_hi   = 20;
                    period_hi = 12;
                end
                2: begin
                    // longest refractory, huge intervals: product runs past 32 bits
                    apply_settings(16'hFFFF, 10'd1000, 8'd0, 8'd255);
                    step_lo   = 5000;
                    step_hi   = 400000;
                    period_hi = 16;
                end
                3: apply_settings(16'($urandom_range(0, 600)), 10'd0, 8'd0, 8'd255);
                4: begin
                    // alternating samples, no refractory: drives the beat count to saturation
                    apply_settings(16'd0, 10'd1, 8'd0, 8'd255);
                    step_lo   = 100;
                    step_hi   = 300;
                    period_hi = 2;
                end
                5: apply_settings(16'($urandom_range(0, 600)), 10'($urandom_range(1, 1000)),
                                  8'd200, 8'd40);
                6: begin
                    // window of exactly 255 bpm
                    apply_settings(16'd1, 10'd1, 8'd255, 8'd255);
                    step_lo   = 110;
                    step_hi   = 125;
                    period_hi = 2;
                end
                default: begin
                    apply_settings(16'($urandom_range(0, 2000)), 10'($urandom_range(1, 1000)),
                                   8'($urandom_range(0, 120)), 8'($urandom_range(100, 255)));
                    period_hi = 30;
                end
            endcase
            sender_gaps   = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            receiver_gaps = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                sender_gaps      = 1'b1;
                receiver_gaps    = 1'b1;
                hold_off_request = 1'b1;
            end
            send_heartbeat_train((phase == 4) ? 40 : $urandom_range(50, 70),
                                 step_lo, step_hi, period_hi, phase == 4);
            s_valid <= 1'b0;
        end

        // Drain, then allow for anything stray still coming out
        while (sb.expected_rates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        run_done = 1'b1;

        if (sb.expected_rates.size() != 0)
            $display("%0d expected results never arrived", sb.expected_rates.size());
        $display("Covered %0d samples under %0d register settings: %0d beats, %0d good rates.",
                 sb.samples_seen, settings_applied, sb.beats_predicted, sb.valid_rates);
        $display("Beat counter saturated: %s; %0d results checked, %0d mismatches.",
                 sb.saturated ? "yes" : "no", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_rates.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
